### hw/rtl/cpbd_pkg.sv
// cpbd_pkg: shared types, constants and the control program of the cascaded pi duty core
// no dependencies; used by cascaded_pi_boost_duty_core through scoped names
package cpbd_pkg;

    // register map, index = paddr / 4
    localparam logic [2:0] REG_VOLTAGE_SETPOINT  = 3'd0;
    localparam logic [2:0] REG_VOLTAGE_PROP_GAIN = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_INT_GAIN  = 3'd2;
    localparam logic [2:0] REG_CURRENT_PROP_GAIN = 3'd3;
    localparam logic [2:0] REG_CURRENT_INT_GAIN  = 3'd4;
    localparam logic [2:0] REG_PWM_PERIOD        = 3'd5;
    localparam logic [2:0] REG_COMPARE_FALLBACK  = 3'd6;

    localparam logic [21:0] RST_VOLTAGE_SETPOINT  = 22'd1310720;
    localparam logic [19:0] RST_VOLTAGE_PROP_GAIN = 20'd3822;
    localparam logic [19:0] RST_VOLTAGE_INT_GAIN  = 20'd71518;
    localparam logic [19:0] RST_CURRENT_PROP_GAIN = 20'd1690;
    localparam logic [19:0] RST_CURRENT_INT_GAIN  = 20'd131927;
    localparam logic [15:0] RST_PWM_PERIOD        = 16'd2250;
    localparam logic [15:0] RST_COMPARE_FALLBACK  = 16'd2200;

    // multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 50 us in Q0.40, and ceil(2^27 / 10) for the divide by ten
    localparam logic [MUL_B_W-1:0] DT_Q40      = 26'd54975581;
    localparam logic [MUL_B_W-1:0] RECIP_TEN   = 26'd13421773;

    localparam logic [16:0] DUTY_ONE      = 17'd65536;
    localparam logic [16:0] DUTY_HIGH_SUB = 17'd58982;
    localparam logic [16:0] DUTY_LOW_SUB  = 17'd6554;

    localparam logic [1:0] SUB_NONE = 2'd0;
    localparam logic [1:0] SUB_HIGH = 2'd1;
    localparam logic [1:0] SUB_LOW  = 2'd2;

    // sequencer
    localparam int PROG_LEN = 18;
    localparam int PC_W     = $clog2(PROG_LEN);
    typedef logic [PC_W-1:0] pc_t;

    typedef logic [1:0] cond_t;
    localparam cond_t COND_NEXT     = 2'd0;
    localparam cond_t COND_WAIT_IN  = 2'd1;
    localparam cond_t COND_WAIT_OUT = 2'd2;
    localparam cond_t COND_JUMP     = 2'd3;

    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_NONE = 3'd0;
    localparam mul_op_t MUL_DT   = 3'd1;
    localparam mul_op_t MUL_PG   = 3'd2;
    localparam mul_op_t MUL_ILO  = 3'd3;
    localparam mul_op_t MUL_IHI  = 3'd4;
    localparam mul_op_t MUL_CONV = 3'd5;
    localparam mul_op_t MUL_CMP  = 3'd6;

    typedef logic [3:0] wr_op_t;
    localparam wr_op_t WR_NONE    = 4'd0;
    localparam wr_op_t WR_CAPTURE = 4'd1;
    localparam wr_op_t WR_INT     = 4'd2;
    localparam wr_op_t WR_PTERM   = 4'd3;
    localparam wr_op_t WR_LO      = 4'd4;
    localparam wr_op_t WR_IADD    = 4'd5;
    localparam wr_op_t WR_AMPS    = 4'd6;
    localparam wr_op_t WR_IREF    = 4'd7;
    localparam wr_op_t WR_IERR    = 4'd8;
    localparam wr_op_t WR_DUTY    = 4'd9;
    localparam wr_op_t WR_OUT     = 4'd10;

    localparam logic LOOP_V = 1'b0;
    localparam logic LOOP_I = 1'b1;

    typedef struct packed {
        cond_t   cond;
        pc_t     target;
        logic    loop;
        mul_op_t mul;
        wr_op_t  wr;
        logic    ld_mag;
    } ctrl_word_t;

    // microprogram; a product is consumed in the step after it is issued
    function automatic ctrl_word_t prog_word(input pc_t pc);
        ctrl_word_t w;
        w = '{cond: COND_NEXT, target: '0, loop: LOOP_V, mul: MUL_NONE,
              wr: WR_NONE, ld_mag: 1'b0};
        unique case (pc)
            pc_t'(0): begin
                w.cond = COND_WAIT_IN;
                w.wr   = WR_CAPTURE;
            end
            pc_t'(1): w.mul = MUL_DT;
            pc_t'(2): begin
                w.wr  = WR_INT;
                w.mul = MUL_PG;
            end
            pc_t'(3): begin
                w.wr     = WR_PTERM;
                w.ld_mag = 1'b1;
                w.mul    = MUL_CONV;
            end
            pc_t'(4): begin
                w.wr  = WR_AMPS;
                w.mul = MUL_ILO;
            end
            pc_t'(5): begin
                w.wr  = WR_LO;
                w.mul = MUL_IHI;
            end
            pc_t'(6): w.wr = WR_IADD;
            pc_t'(7): w.wr = WR_IREF;
            pc_t'(8): w.wr = WR_IERR;
            pc_t'(9): begin
                w.loop = LOOP_I;
                w.mul  = MUL_DT;
            end
            pc_t'(10): begin
                w.loop = LOOP_I;
                w.wr   = WR_INT;
                w.mul  = MUL_PG;
            end
            pc_t'(11): begin
                w.loop   = LOOP_I;
                w.wr     = WR_PTERM;
                w.ld_mag = 1'b1;
            end
            pc_t'(12): begin
                w.loop = LOOP_I;
                w.mul  = MUL_ILO;
            end
            pc_t'(13): begin
                w.loop = LOOP_I;
                w.wr   = WR_LO;
                w.mul  = MUL_IHI;
            end
            pc_t'(14): begin
                w.loop = LOOP_I;
                w.wr   = WR_IADD;
            end
            pc_t'(15): w.wr = WR_DUTY;
            pc_t'(16): w.mul = MUL_CMP;
            pc_t'(17): begin
                w.cond   = COND_WAIT_OUT;
                w.target = pc_t'(0);
                w.wr     = WR_OUT;
            end
            default: begin
                w.cond   = COND_JUMP;
                w.target = pc_t'(0);
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/cascaded_pi_boost_duty_core.sv
// cascaded_pi_boost_duty_core: cascaded voltage/current pi loops producing a pwm compare
// depends on cpbd_pkg for the register map, constants and the control program
//
// Usage: each word on the s_ channel is one pair of adc samples (output voltage and
// inductor current). The outer loop turns the voltage error into a current reference,
// the inner loop turns the current error into a duty, and the duty times the pwm period
// gives the compare count. One result word per input word leaves on the m_ channel.
// Control is an 18-step program that runs one shared multiplier and one accumulator;
// s_ready is high only at the program's first step. A word is accepted at that step, its
// result enters the output register at the last step, and the next word cannot be taken
// until the program has returned to its first step. If the receiver stalls, the result is
// held in the output register and the program waits at its last step until the output
// register frees; an input word can still be accepted and worked on while the previous
// result waits. Registers are to be written by the user through the apb port only while
// the block is idle; the block itself does not enforce it. pready is always high. Reset
// returns all registers to their defaults, zeroes both integrators and empties the
// output register.
module cascaded_pi_boost_duty_core #(
    parameter int SAMPLE_BITS     = 12,
    parameter int INTEGRATOR_BITS = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_BITS-1:0]     s_voltage_sample,
    input  logic [SAMPLE_BITS-1:0]     s_current_sample,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [15:0]                m_compare_value,
    output logic [16:0]                m_duty_fraction,
    output logic signed [31:0]         m_current_reference,
    output logic [1:0]                 m_duty_substitution,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int IB     = INTEGRATOR_BITS;
    localparam int SUM_W  = ((IB > 35) ? IB : 35) + 1;
    localparam int ACC_W  = ((IB - 11) > 38) ? (IB - 11) : 38;
    localparam int PW     = cpbd_pkg::PROD_W;

    localparam logic [SUM_W-1:0] INT_MAX = {{(SUM_W - IB + 1){1'b0}}, {(IB - 1){1'b1}}};
    localparam logic [SUM_W-1:0] INT_MIN = ~INT_MAX;
    localparam logic [ACC_W-1:0] IREF_MAX = ACC_W'(32'h7FFF_FFFF);
    localparam logic [ACC_W-1:0] IREF_MIN = ~IREF_MAX;

    // configuration registers
    logic [21:0] voltage_setpoint_reg, voltage_setpoint_next;
    logic [19:0] voltage_prop_gain_reg, voltage_prop_gain_next;
    logic [19:0] voltage_int_gain_reg, voltage_int_gain_next;
    logic [19:0] current_prop_gain_reg, current_prop_gain_next;
    logic [19:0] current_int_gain_reg, current_int_gain_next;
    logic [15:0] pwm_period_reg, pwm_period_next;
    logic [15:0] compare_fallback_reg, compare_fallback_next;

    // sequencer
    cpbd_pkg::pc_t        pc_reg, pc_next;
    cpbd_pkg::ctrl_word_t cw;

    // datapath
    logic [IB-1:0]      vint_reg, vint_next;
    logic [IB-1:0]      iint_reg, iint_next;
    logic [31:0]        errmag_reg, errmag_next;
    logic               err_neg_reg, err_neg_next;
    logic [63:0]        intmag_reg, intmag_next;
    logic               int_neg_reg, int_neg_next;
    logic [22:0]        amp_scaled_reg, amp_scaled_next;
    logic [19:0]        amps_reg, amps_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [31:0]        iref_reg, iref_next;
    logic [16:0]        duty_reg, duty_next;
    logic [1:0]         sub_reg, sub_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_compare_value_reg, m_compare_value_next;
    logic [16:0]        m_duty_fraction_reg, m_duty_fraction_next;
    logic [31:0]        m_current_reference_reg, m_current_reference_next;
    logic [1:0]         m_duty_substitution_reg, m_duty_substitution_next;

    logic                              accept_in;
    logic                              out_free;
    logic                              cfg_wr;
    logic [21:0]                       volts;
    logic [22:0]                       amp_scaled;
    logic [cpbd_pkg::MUL_A_W-1:0]      mul_a;
    logic [cpbd_pkg::MUL_B_W-1:0]      mul_b;
    logic [IB-1:0]                     int_sel;
    logic [IB-1:0]                     int_abs;
    logic [SUM_W-1:0]                  inc_w;
    logic [SUM_W-1:0]                  sum_w;
    logic [IB-1:0]                     int_new;
    logic [32:0]                       iref_x;
    logic [32:0]                       amps_x;
    logic                              iref_ge;
    logic [16:0]                       cmp_full;

    assign cw        = cpbd_pkg::prog_word(pc_reg);
    assign s_ready   = (cw.cond == cpbd_pkg::COND_WAIT_IN);
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration write and read
    always_comb begin
        voltage_setpoint_next  = voltage_setpoint_reg;
        voltage_prop_gain_next = voltage_prop_gain_reg;
        voltage_int_gain_next  = voltage_int_gain_reg;
        current_prop_gain_next = current_prop_gain_reg;
        current_int_gain_next  = current_int_gain_reg;
        pwm_period_next        = pwm_period_reg;
        compare_fallback_next  = compare_fallback_reg;
        if (cfg_wr) begin
            unique case (paddr[4:2])
                cpbd_pkg::REG_VOLTAGE_SETPOINT:  voltage_setpoint_next  = pwdata[21:0];
                cpbd_pkg::REG_VOLTAGE_PROP_GAIN: voltage_prop_gain_next = pwdata[19:0];
                cpbd_pkg::REG_VOLTAGE_INT_GAIN:  voltage_int_gain_next  = pwdata[19:0];
                cpbd_pkg::REG_CURRENT_PROP_GAIN: current_prop_gain_next = pwdata[19:0];
                cpbd_pkg::REG_CURRENT_INT_GAIN:  current_int_gain_next  = pwdata[19:0];
                cpbd_pkg::REG_PWM_PERIOD:        pwm_period_next        = pwdata[15:0];
                cpbd_pkg::REG_COMPARE_FALLBACK:  compare_fallback_next  = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            cpbd_pkg::REG_VOLTAGE_SETPOINT:  prdata = 32'(voltage_setpoint_reg);
            cpbd_pkg::REG_VOLTAGE_PROP_GAIN: prdata = 32'(voltage_prop_gain_reg);
            cpbd_pkg::REG_VOLTAGE_INT_GAIN:  prdata = 32'(voltage_int_gain_reg);
            cpbd_pkg::REG_CURRENT_PROP_GAIN: prdata = 32'(current_prop_gain_reg);
            cpbd_pkg::REG_CURRENT_INT_GAIN:  prdata = 32'(current_int_gain_reg);
            cpbd_pkg::REG_PWM_PERIOD:        prdata = 32'(pwm_period_reg);
            cpbd_pkg::REG_COMPARE_FALLBACK:  prdata = 32'(compare_fallback_reg);
            default:                         prdata = '0;
        endcase
    end

    // step counter
    always_comb begin
        unique case (cw.cond)
            cpbd_pkg::COND_NEXT:     pc_next = pc_reg + cpbd_pkg::pc_t'(1);
            cpbd_pkg::COND_WAIT_IN:  pc_next = accept_in ? pc_reg + cpbd_pkg::pc_t'(1) : pc_reg;
            cpbd_pkg::COND_WAIT_OUT: pc_next = out_free ? cw.target : pc_reg;
            cpbd_pkg::COND_JUMP:     pc_next = cw.target;
        endcase
    end

    // sample scaling: volts = s * 33 / 2^n in q16.16, current pre-scaled by 66 before /10
    assign volts      = 22'(22'(s_voltage_sample) * 22'd33) << (16 - SAMPLE_BITS);
    assign amp_scaled = 23'(23'(s_current_sample) * 23'd66) << (16 - SAMPLE_BITS);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cw.mul)
            cpbd_pkg::MUL_DT: begin
                mul_a = errmag_reg;
                mul_b = cpbd_pkg::DT_Q40;
            end
            cpbd_pkg::MUL_PG: begin
                mul_a = errmag_reg;
                mul_b = (cw.loop == cpbd_pkg::LOOP_I) ? 26'(current_prop_gain_reg)
                                                      : 26'(voltage_prop_gain_reg);
            end
            cpbd_pkg::MUL_ILO: begin
                mul_a = intmag_reg[31:0];
                mul_b = (cw.loop == cpbd_pkg::LOOP_I) ? 26'(current_int_gain_reg)
                                                      : 26'(voltage_int_gain_reg);
            end
            cpbd_pkg::MUL_IHI: begin
                mul_a = intmag_reg[63:32];
                mul_b = (cw.loop == cpbd_pkg::LOOP_I) ? 26'(current_int_gain_reg)
                                                      : 26'(voltage_int_gain_reg);
            end
            cpbd_pkg::MUL_CONV: begin
                mul_a = 32'(amp_scaled_reg);
                mul_b = cpbd_pkg::RECIP_TEN;
            end
            cpbd_pkg::MUL_CMP: begin
                mul_a = 32'(duty_reg);
                mul_b = 26'(pwm_period_reg);
            end
            default: ;
        endcase
        prod_next = (cw.mul != cpbd_pkg::MUL_NONE) ? PW'(mul_a) * PW'(mul_b) : prod_reg;
    end

    // integrator add with saturation at the integrator width
    assign int_sel = (cw.loop == cpbd_pkg::LOOP_I) ? iint_reg : vint_reg;
    assign int_abs = int_sel[IB-1] ? (~int_sel + IB'(1)) : int_sel;
    assign inc_w   = err_neg_reg ? (SUM_W'(0) - SUM_W'(prod_reg[57:24]))
                                 : SUM_W'(prod_reg[57:24]);
    assign sum_w   = {{(SUM_W - IB){int_sel[IB-1]}}, int_sel} + inc_w;

    always_comb begin
        priority if ($signed(sum_w) > $signed(INT_MAX)) begin
            int_new = INT_MAX[IB-1:0];
        end else if ($signed(sum_w) < $signed(INT_MIN)) begin
            int_new = INT_MIN[IB-1:0];
        end else begin
            int_new = sum_w[IB-1:0];
        end
    end

    assign iref_x  = {iref_reg[31], iref_reg};
    assign amps_x  = 33'(amps_reg);
    assign iref_ge = $signed(iref_x) >= $signed(amps_x);
    assign cmp_full = prod_reg[32:16];

    // datapath register updates
    always_comb begin
        vint_next       = vint_reg;
        iint_next       = iint_reg;
        errmag_next     = errmag_reg;
        err_neg_next    = err_neg_reg;
        intmag_next     = intmag_reg;
        int_neg_next    = int_neg_reg;
        amp_scaled_next = amp_scaled_reg;
        amps_next       = amps_reg;
        acc_next        = acc_reg;
        iref_next       = iref_reg;
        duty_next       = duty_reg;
        sub_next        = sub_reg;

        m_valid_next             = m_valid_reg && !m_ready;
        m_compare_value_next     = m_compare_value_reg;
        m_duty_fraction_next     = m_duty_fraction_reg;
        m_current_reference_next = m_current_reference_reg;
        m_duty_substitution_next = m_duty_substitution_reg;

        if (cw.ld_mag) begin
            intmag_next  = 64'(int_abs);
            int_neg_next = int_sel[IB-1];
        end

        unique case (cw.wr)
            cpbd_pkg::WR_CAPTURE: begin
                if (accept_in) begin
                    err_neg_next    = voltage_setpoint_reg < volts;
                    errmag_next     = (voltage_setpoint_reg >= volts)
                                      ? 32'(voltage_setpoint_reg - volts)
                                      : 32'(volts - voltage_setpoint_reg);
                    amp_scaled_next = amp_scaled;
                end
            end
            cpbd_pkg::WR_INT: begin
                if (cw.loop == cpbd_pkg::LOOP_I) begin
                    iint_next = int_new;
                end else begin
                    vint_next = int_new;
                end
            end
            cpbd_pkg::WR_PTERM: begin
                acc_next = err_neg_reg ? (ACC_W'(0) - ACC_W'(prod_reg[51:16]))
                                       : ACC_W'(prod_reg[51:16]);
            end
            // low half of the integral times gain, shifted down by 32
            cpbd_pkg::WR_LO: begin
                acc_next = int_neg_reg ? (acc_reg - ACC_W'(prod_reg[51:32]))
                                       : (acc_reg + ACC_W'(prod_reg[51:32]));
            end
            cpbd_pkg::WR_IADD: begin
                acc_next = int_neg_reg ? (acc_reg - ACC_W'(prod_reg[ACC_W-2:0]))
                                       : (acc_reg + ACC_W'(prod_reg[ACC_W-2:0]));
            end
            cpbd_pkg::WR_AMPS: begin
                amps_next = prod_reg[46:27];
            end
            cpbd_pkg::WR_IREF: begin
                priority if ($signed(acc_reg) > $signed(IREF_MAX)) begin
                    iref_next = IREF_MAX[31:0];
                end else if ($signed(acc_reg) < $signed(IREF_MIN)) begin
                    iref_next = IREF_MIN[31:0];
                end else begin
                    iref_next = acc_reg[31:0];
                end
            end
            cpbd_pkg::WR_IERR: begin
                err_neg_next = !iref_ge;
                errmag_next  = iref_ge ? 32'(iref_x - amps_x) : 32'(amps_x - iref_x);
            end
            cpbd_pkg::WR_DUTY: begin
                priority if ($signed(acc_reg) > $signed(ACC_W'(cpbd_pkg::DUTY_ONE))) begin
                    duty_next = cpbd_pkg::DUTY_HIGH_SUB;
                    sub_next  = cpbd_pkg::SUB_HIGH;
                end else if (acc_reg[ACC_W-1]) begin
                    duty_next = cpbd_pkg::DUTY_LOW_SUB;
                    sub_next  = cpbd_pkg::SUB_LOW;
                end else begin
                    duty_next = acc_reg[16:0];
                    sub_next  = cpbd_pkg::SUB_NONE;
                end
            end
            cpbd_pkg::WR_OUT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_compare_value_next     = (cmp_full > {1'b0, pwm_period_reg})
                                               ? compare_fallback_reg : cmp_full[15:0];
                    m_duty_fraction_next     = duty_reg;
                    m_current_reference_next = iref_reg;
                    m_duty_substitution_next = sub_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voltage_setpoint_reg  <= cpbd_pkg::RST_VOLTAGE_SETPOINT;
            voltage_prop_gain_reg <= cpbd_pkg::RST_VOLTAGE_PROP_GAIN;
            voltage_int_gain_reg  <= cpbd_pkg::RST_VOLTAGE_INT_GAIN;
            current_prop_gain_reg <= cpbd_pkg::RST_CURRENT_PROP_GAIN;
            current_int_gain_reg  <= cpbd_pkg::RST_CURRENT_INT_GAIN;
            pwm_period_reg        <= cpbd_pkg::RST_PWM_PERIOD;
            compare_fallback_reg  <= cpbd_pkg::RST_COMPARE_FALLBACK;
            pc_reg                <= '0;
            vint_reg              <= '0;
            iint_reg              <= '0;
            m_valid_reg           <= 1'b0;
        end else begin
            voltage_setpoint_reg  <= voltage_setpoint_next;
            voltage_prop_gain_reg <= voltage_prop_gain_next;
            voltage_int_gain_reg  <= voltage_int_gain_next;
            current_prop_gain_reg <= current_prop_gain_next;
            current_int_gain_reg  <= current_int_gain_next;
            pwm_period_reg        <= pwm_period_next;
            compare_fallback_reg  <= compare_fallback_next;
            pc_reg                <= pc_next;
            vint_reg              <= vint_next;
            iint_reg              <= iint_next;
            m_valid_reg           <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        errmag_reg              <= errmag_next;
        err_neg_reg             <= err_neg_next;
        intmag_reg              <= intmag_next;
        int_neg_reg             <= int_neg_next;
        amp_scaled_reg          <= amp_scaled_next;
        amps_reg                <= amps_next;
        prod_reg                <= prod_next;
        acc_reg                 <= acc_next;
        iref_reg                <= iref_next;
        duty_reg                <= duty_next;
        sub_reg                 <= sub_next;
        m_compare_value_reg     <= m_compare_value_next;
        m_duty_fraction_reg     <= m_duty_fraction_next;
        m_current_reference_reg <= m_current_reference_next;
        m_duty_substitution_reg <= m_duty_substitution_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_compare_value     = m_compare_value_reg;
    assign m_duty_fraction     = m_duty_fraction_reg;
    assign m_current_reference = $signed(m_current_reference_reg);
    assign m_duty_substitution = m_duty_substitution_reg;

endmodule

### verif/cpbd_checker.sv
// cpbd_checker: watches the sample, result and register ports of the cascaded pi duty core,
// predicts every result word in its own fixed-point arithmetic and compares field by field
// depends on cpbd_pkg for register indexes, reset values and duty constants
module cpbd_checker #(
    parameter int SAMPLE_BITS     = 12,
    parameter int INTEGRATOR_BITS = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_voltage_sample,
    input  logic [SAMPLE_BITS-1:0] s_current_sample,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [15:0]            m_compare_value,
    input  logic [16:0]            m_duty_fraction,
    input  logic signed [31:0]     m_current_reference,
    input  logic [1:0]             m_duty_substitution,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,

    output int                     words_waiting,
    output int                     mismatches,
    output int                     words_checked,
    output int                     high_clamps,
    output int                     low_clamps
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [15:0]        compare_value;
        logic [16:0]        duty_fraction;
        logic signed [31:0] current_reference;
        logic [1:0]         duty_substitution;
    } pwm_word_t;

    localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRATOR_BITS - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint IREF_MAX  = 64'sd2147483647;
    localparam longint IREF_MIN  = -64'sd2147483648;

    logic [21:0] setpoint;
    logic [19:0] v_kp, v_ki, i_kp, i_ki;
    logic [15:0] period, fallback;
    longint      v_integral, i_integral;

    pwm_word_t   pwm_words[$];
    pwm_word_t   want;
    int          errs, n_seen, n_high, n_low;

    // magnitude times k, shifted, sign put back: rounds toward zero
    function automatic longint scaled(input longint v, input u64_t k, input int sh);
        u64_t m;
        m = (v < 0) ? -v : v;
        m = (m * k) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // q.32 integral times q4.16 gain, split so the product never leaves 64 bits
    function automatic longint integral_gain_term(input longint acc, input u64_t g);
        u64_t m, r;
        m = (acc < 0) ? -acc : acc;
        r = (m >> 32) * g + (((m & 64'hFFFF_FFFF) * g) >> 32);
        return (acc < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint integrate_sat(input longint acc, input longint inc);
        if (inc > 0 && acc > INTEG_MAX - inc)
            return INTEG_MAX;
        if (inc < 0 && acc < INTEG_MIN - inc)
            return INTEG_MIN;
        return acc + inc;
    endfunction

    task automatic run_cascade(input logic [SAMPLE_BITS-1:0] vs, input logic [SAMPLE_BITS-1:0] cs,
                               output pwm_word_t w);
        longint volts, amps, verr, iref, ierr, duty;
        u64_t   cmp;
        volts = longint'(vs) * 33 * (longint'(1) << (16 - SAMPLE_BITS));
        amps  = (longint'(cs) * 66 * 65536) / (longint'(10) << SAMPLE_BITS);

        // outer loop: voltage error to current reference
        verr = longint'(setpoint) - volts;
        v_integral = integrate_sat(v_integral, scaled(verr, u64_t'(cpbd_pkg::DT_Q40), 24));
        iref = scaled(verr, u64_t'(v_kp), 16) + integral_gain_term(v_integral, u64_t'(v_ki));
        if (iref > IREF_MAX)
            iref = IREF_MAX;
        else if (iref < IREF_MIN)
            iref = IREF_MIN;

        // inner loop: current error to duty
        ierr = iref - amps;
        i_integral = integrate_sat(i_integral, scaled(ierr, u64_t'(cpbd_pkg::DT_Q40), 24));
        duty = scaled(ierr, u64_t'(i_kp), 16) + integral_gain_term(i_integral, u64_t'(i_ki));

        w.duty_substitution = cpbd_pkg::SUB_NONE;
        if (duty > longint'(cpbd_pkg::DUTY_ONE)) begin
            duty = longint'(cpbd_pkg::DUTY_HIGH_SUB);
            w.duty_substitution = cpbd_pkg::SUB_HIGH;
        end else if (duty < 0) begin
            duty = longint'(cpbd_pkg::DUTY_LOW_SUB);
            w.duty_substitution = cpbd_pkg::SUB_LOW;
        end

        cmp = (u64_t'(duty) * u64_t'(period)) >> 16;
        if (cmp > u64_t'(period))
            cmp = u64_t'(fallback);

        w.compare_value     = cmp[15:0];
        w.duty_fraction     = duty[16:0];
        w.current_reference = iref[31:0];
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            setpoint   = cpbd_pkg::RST_VOLTAGE_SETPOINT;
            v_kp       = cpbd_pkg::RST_VOLTAGE_PROP_GAIN;
            v_ki       = cpbd_pkg::RST_VOLTAGE_INT_GAIN;
            i_kp       = cpbd_pkg::RST_CURRENT_PROP_GAIN;
            i_ki       = cpbd_pkg::RST_CURRENT_INT_GAIN;
            period     = cpbd_pkg::RST_PWM_PERIOD;
            fallback   = cpbd_pkg::RST_COMPARE_FALLBACK;
            v_integral = 0;
            i_integral = 0;
            pwm_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    cpbd_pkg::REG_VOLTAGE_SETPOINT:  setpoint = pwdata[21:0];
                    cpbd_pkg::REG_VOLTAGE_PROP_GAIN: v_kp     = pwdata[19:0];
                    cpbd_pkg::REG_VOLTAGE_INT_GAIN:  v_ki     = pwdata[19:0];
                    cpbd_pkg::REG_CURRENT_PROP_GAIN: i_kp     = pwdata[19:0];
                    cpbd_pkg::REG_CURRENT_INT_GAIN:  i_ki     = pwdata[19:0];
                    cpbd_pkg::REG_PWM_PERIOD:        period   = pwdata[15:0];
                    cpbd_pkg::REG_COMPARE_FALLBACK:  fallback = pwdata[15:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (pwm_words.size() == 0) begin
                    errs++;
                    $error("result word with nothing expected: compare %0d duty %0d",
                           m_compare_value, m_duty_fraction);
                end else begin
                    want = pwm_words.pop_front();
                    n_seen++;
                    if (want.duty_substitution == cpbd_pkg::SUB_HIGH)
                        n_high++;
                    if (want.duty_substitution == cpbd_pkg::SUB_LOW)
                        n_low++;
                    if (m_compare_value !== want.compare_value) begin
                        errs++;
                        $error("compare_value: expected %0d, got %0d",
                               want.compare_value, m_compare_value);
                    end
                    if (m_duty_fraction !== want.duty_fraction) begin
                        errs++;
                        $error("duty_fraction: expected %0d, got %0d",
                               want.duty_fraction, m_duty_fraction);
                    end
                    if (m_current_reference !== want.current_reference) begin
                        errs++;
                        $error("current_reference: expected %0d, got %0d",
                               want.current_reference, m_current_reference);
                    end
                    if (m_duty_substitution !== want.duty_substitution) begin
                        errs++;
                        $error("duty_substitution: expected %0d, got %0d",
                               want.duty_substitution, m_duty_substitution);
                    end
                end
            end

            if (s_valid && s_ready) begin
                run_cascade(s_voltage_sample, s_current_sample, want);
                pwm_words.push_back(want);
            end
        end
        words_waiting <= pwm_words.size();
        mismatches    <= errs;
        words_checked <= n_seen;
        high_clamps   <= n_high;
        low_clamps    <= n_low;
    end

endmodule

### verif/tb_cascaded_pi_boost_duty_core.sv
// tb_cascaded_pi_boost_duty_core: drives adc sample words and register writes into the core
// with random gaps and result stalls; depends on cpbd_pkg, the core and cpbd_checker
// directed corner words first, then randomly configured phases of near-setpoint and noise words
module tb_cascaded_pi_boost_duty_core;

    localparam int SAMPLE_BITS     = 12;
    localparam int INTEGRATOR_BITS = 48;
    localparam int WORDS_PER_PHASE = 130;
    localparam int RANDOM_PHASES   = 8;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_voltage_sample;
    logic [SAMPLE_BITS-1:0] s_current_sample;
    logic                   m_valid;
    logic                   m_ready;
    logic [15:0]            m_compare_value;
    logic [16:0]            m_duty_fraction;
    logic signed [31:0]     m_current_reference;
    logic [1:0]             m_duty_substitution;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [4:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    int words_waiting, mismatches, words_checked, high_clamps, low_clamps;
    int settings_used;
    logic rush;

    cascaded_pi_boost_duty_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .INTEGRATOR_BITS(INTEGRATOR_BITS)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_voltage_sample   (s_voltage_sample),
        .s_current_sample   (s_current_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_compare_value    (m_compare_value),
        .m_duty_fraction    (m_duty_fraction),
        .m_current_reference(m_current_reference),
        .m_duty_substitution(m_duty_substitution),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    cpbd_checker #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .INTEGRATOR_BITS(INTEGRATOR_BITS)
    ) u_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_voltage_sample   (s_voltage_sample),
        .s_current_sample   (s_current_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_compare_value    (m_compare_value),
        .m_duty_fraction    (m_duty_fraction),
        .m_current_reference(m_current_reference),
        .m_duty_substitution(m_duty_substitution),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .words_waiting      (words_waiting),
        .mismatches         (mismatches),
        .words_checked      (words_checked),
        .high_clamps        (high_clamps),
        .low_clamps         (low_clamps)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stall before each word, none while rushing
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = rush ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] vs,
                               input logic [SAMPLE_BITS-1:0] cs);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_voltage_sample <= vs;
        s_current_sample <= cs;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // hold off new words until every predicted word has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (words_waiting != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [31:0] sp, input logic [31:0] vkp,
                               input logic [31:0] vki, input logic [31:0] ikp,
                               input logic [31:0] iki, input logic [31:0] per,
                               input logic [31:0] fb);
        reg_write(cpbd_pkg::REG_VOLTAGE_SETPOINT, sp);
        reg_write(cpbd_pkg::REG_VOLTAGE_PROP_GAIN, vkp);
        reg_write(cpbd_pkg::REG_VOLTAGE_INT_GAIN, vki);
        reg_write(cpbd_pkg::REG_CURRENT_PROP_GAIN, ikp);
        reg_write(cpbd_pkg::REG_CURRENT_INT_GAIN, iki);
        reg_write(cpbd_pkg::REG_PWM_PERIOD, per);
        reg_write(cpbd_pkg::REG_COMPARE_FALLBACK, fb);
        settings_used++;
    endtask

    // log-spread gain so small loop gains (duty inside 0..1) come up often
    function automatic logic [31:0] rand_gain();
        return $urandom_range(0, (1 << $urandom_range(0, 20)) - 1);
    endfunction

    initial begin : stimulus
        int ph, k, pick, vc, center;
        logic [31:0] sp;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_voltage_sample = '0;
        s_current_sample = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        rush             = 1'b0;
        settings_used    = 1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: full-scale corners, alternating bits, words near 20 V
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd0, 12'd4095);
        send_sample(12'd4095, 12'd0);
        send_sample(12'hAAA, 12'h555);
        send_sample(12'h555, 12'hAAA);
        send_sample(12'd2482, 12'd0);
        send_sample(12'd2482, 12'd100);
        send_sample(12'd2483, 12'd200);
        drain();

        // every register at its low end but the period, which is one: zero gains give zero duty
        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        drain();

        // gains and setpoint at full scale, zero period forces a zero compare
        load_config(32'd4194303, 32'd1048575, 32'd1048575, 32'd1048575, 32'd1048575,
                    32'd0, 32'd65535);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd2000, 12'd2000);
        drain();

        // widest period and fallback; a write past the register map must change nothing
        load_config(32'(cpbd_pkg::RST_VOLTAGE_SETPOINT), 32'(cpbd_pkg::RST_VOLTAGE_PROP_GAIN),
                    32'(cpbd_pkg::RST_VOLTAGE_INT_GAIN), 32'(cpbd_pkg::RST_CURRENT_PROP_GAIN),
                    32'(cpbd_pkg::RST_CURRENT_INT_GAIN), 32'd65535, 32'd65535);
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd2482, 12'd1000);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            rush = (ph % 4 == 3);
            if (ph == 0)
                sp = 32'(cpbd_pkg::RST_VOLTAGE_SETPOINT);
            else if (ph == 5)
                sp = $urandom;
            else
                sp = $urandom_range(0, 4194303);
            if (ph == 5)
                load_config(sp, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                load_config(sp, rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                            $urandom_range(1, 65535), $urandom_range(0, 65535));

            // sample value that reads back as the setpoint voltage
            center = int'(sp[21:0] / 528);
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    vc = center + int'($urandom_range(0, 32)) - 16;
                    if (vc < 0)
                        vc = 0;
                    if (vc > 4095)
                        vc = 4095;
                    send_sample(vc[11:0], 12'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                                 : $urandom_range(0, 4095)));
                end else if (pick < 9) begin
                    send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                end else begin
                    send_sample($urandom_range(0, 1) ? 12'd4095 : 12'd0,
                                $urandom_range(0, 1) ? 12'd4095 : 12'd0);
                end
                if (ph == 2 && k == WORDS_PER_PHASE / 2)
                    drain();
            end
            drain();
        end
        rush = 1'b0;

        repeat (40) @(negedge aclk);
        $display("checked %0d result words over %0d register settings", words_checked,
                 settings_used);
        $display("duty replaced above one %0d times, below zero %0d times", high_clamps,
                 low_clamps);
        if (mismatches == 0 && words_waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/cpbd_pkg.sv
hw/rtl/cascaded_pi_boost_duty_core.sv
verif/cpbd_checker.sv
verif/tb_cascaded_pi_boost_duty_core.sv
